### sv/assert_macros.svh
// concurrent assertion helpers for the tick generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside reset
`define DCTG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dctg assertion failed");

// checked on every rising edge, reset included
`define DCTG_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("dctg assertion failed");

`else

`define DCTG_ASSERT(name, clk, rst, prop)
`define DCTG_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

### sv/dctg_pkg.sv
`timescale 1ns / 1ps

package dctg_pkg;

   // register widths and reset values
   localparam int INC_W    = 31;
   localparam int PERIOD_W = 16;
   localparam logic [INC_W-1:0]    INC_RESET    = 31'd328;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;

   // stream word widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = 31;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   // register indexes
   localparam logic CSR_TICK_INCREMENT = 1'b0;
   localparam logic CSR_DRIFT_PERIOD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_DIV,
      ST_ADV,
      ST_DRIFT,
      ST_DONE
   } dctg_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic advance;
      logic drift_chk;
      logic out_load;
   } dctg_cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_busy;
      logic div_needed;
      logic div_last;
      logic out_free;
   } dctg_sts_type;

endpackage

### sv/dctg_ctrl.sv
`timescale 1ns / 1ps

module dctg_ctrl import dctg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dctg_sts_type sts,
   output dctg_cmd_type cmd
);

   dctg_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            if (sts.is_start || sts.is_busy) begin
               state_in = ST_DONE;
            end else if (sts.div_needed) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_DRIFT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = ST_DRIFT;
         end
         ST_DRIFT: begin
            cmd.drift_chk = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/dctg_dp.sv
`timescale 1ns / 1ps

module dctg_dp import dctg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [INC_W-1:0]       csr_wdata,
   input  dctg_cmd_type           cmd,
   output dctg_sts_type           sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [INC_W-1:0]       inc_ff, inc_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [31:0]            base_ff, base_in;
   logic [31:0]            drift_ff, drift_in;
   logic                   op_ff, op_in;
   logic                   busy_ff, busy_in;
   logic [31:0]            diff_ff, diff_in;
   logic [INC_W-1:0]       rem_ff, rem_in;
   logic [INC_W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [31:0]            tick_ff, tick_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] sample;
   logic [31:0] diff_load;
   logic [31:0] shifted;
   logic [32:0] trial;
   logic [31:0] adv;
   logic [31:0] n_ticks;
   logic [32:0] drift_sum;
   logic [31:0] next_match;
   logic        rej;

   assign sample     = req_tdata[31:0];
   assign diff_load  = sample - base_ff;
   assign shifted    = {rem_ff, quo_ff[INC_W-1]};
   assign trial      = {1'b0, shifted} - {2'b00, inc_ff};
   // (diff - 1 - rem) is quotient times increment; one more increment for the ceiling
   assign adv        = diff_ff - 32'd1 - {1'b0, rem_ff} + {1'b0, inc_ff};
   assign n_ticks    = {1'b0, quo_ff} + 32'd1;
   assign drift_sum  = {1'b0, drift_ff} + {1'b0, n_ticks};
   assign next_match = base_ff + {1'b0, inc_ff};
   assign rej        = (op_ff == OP_MATCH) && busy_ff;

   always_comb begin
      inc_in       = inc_ff;
      period_in    = period_ff;
      base_in      = base_ff;
      drift_in     = drift_ff;
      op_in        = op_ff;
      busy_in      = busy_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TICK_INCREMENT: inc_in    = csr_wdata;
            CSR_DRIFT_PERIOD:   period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         op_in   = req_tuser;
         busy_in = req_tdata[32];
         diff_in = diff_load;
         quo_in  = diff_load[INC_W-1:0] - INC_W'(1);
         rem_in  = '0;
         cnt_in  = '0;
         tick_in = '0;
         if (req_tuser == OP_START) begin
            base_in = sample;
         end
      end

      if (cmd.div_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (!trial[32]) begin
            rem_in = trial[INC_W-1:0];
            quo_in = {quo_ff[INC_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[INC_W-1:0];
            quo_in = {quo_ff[INC_W-2:0], 1'b0};
         end
      end

      if (cmd.advance) begin
         tick_in  = n_ticks;
         base_in  = base_ff + adv;
         drift_in = drift_sum[32] ? 32'hffff_ffff : drift_sum[31:0];
      end

      if (cmd.drift_chk && (drift_ff >= {16'h0000, period_ff})) begin
         drift_in = drift_ff - {16'h0000, period_ff};
         tick_in  = tick_ff + 32'd1;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, rej, next_match, tick_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff       <= INC_RESET;
         period_ff    <= PERIOD_RESET;
         base_ff      <= '0;
         drift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inc_ff       <= inc_in;
         period_ff    <= period_in;
         base_ff      <= base_in;
         drift_ff     <= drift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      busy_ff     <= busy_in;
      diff_ff     <= diff_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      tick_ff     <= tick_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.is_start   = (op_ff == OP_START);
   assign sts.is_busy    = rej;
   assign sts.div_needed = (diff_ff != 32'd0) && !diff_ff[31] && (inc_ff != '0);
   assign sts.div_last   = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/drift_corrected_tick_generator_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Drift-corrected system tick generator. Each request word carries a sample
// of a free-running 32-bit counter; a start word sets the match base to it,
// a match word measures the signed elapsed count since the base and issues
// ceil(elapsed / tick_increment) ticks, moving the base on by that many
// increments, plus one correction tick whenever the saturating drift count
// reaches drift_period. A match word with match_busy set is rejected and
// changes nothing. Every request gives exactly one response word with the
// tick count, the next match value (base plus increment) and the reject flag.
// One word is in work at a time. A start or rejected word passes route and
// done; a match word with positive elapsed count and nonzero increment
// passes route, the 31-step restoring divider that finds the tick count one
// quotient bit per cycle, advance, drift check and done; any other match
// word passes route, drift check and done. The next word is accepted in the
// cycle after the response is loaded; the sequencer waits only while the
// response register is full and unread, so a held response stalls requests.
// The user must write registers only while no word is in work (not enforced).

module drift_corrected_tick_generator_core import dctg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] counter_sample, [32] match_busy
   input  logic                   req_tuser,   // [0] operation
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] tick_count, [63:32] next_match,
                                               // [64] rejected
   // register write port
   input  logic                   csr_wr_en,
   input  logic                   csr_index,   // 0 tick_increment, 1 drift_period
   input  logic [INC_W-1:0]       csr_wdata
);

   // command and status between sequencer and datapath
   dctg_cmd_type cmd;
   dctg_sts_type sts;

   // response fields seen by the checks
   logic [31:0] rsp_ticks;
   logic        rsp_rejected;

   assign rsp_ticks    = rsp_tdata[31:0];
   assign rsp_rejected = rsp_tdata[64];

   // sequencer: accept, route by kind, divide, advance base, drift check, respond
   dctg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: registers, base and drift state, divider and response register
   dctg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // one word in work at a time: an accepted word closes the request side
   `DCTG_ASSERT(a_one_in_flight, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // a rejected word never carries ticks
   `DCTG_ASSERT(a_reject_no_ticks, clock, reset, (rsp_tvalid && rsp_rejected) |-> (rsp_ticks == 32'd0))

   // ticks are bounded by the largest positive elapsed count plus the correction tick
   `DCTG_ASSERT(a_tick_bound, clock, reset, rsp_tvalid |-> (rsp_ticks <= 32'h8000_0000))

endmodule
